// ===== rtl/bbe_pkg.sv =====
// shared constants, types and helper functions of the border extractor
`default_nettype none

package bbe_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int ROW_W      = HEIGHT_W + 1;
    localparam int PIXEL_W    = 8;
    localparam int PRIME_W    = $clog2(MAX_WIDTH + 2);
    localparam int CMP_W      = (WIDTH_W > PRIME_W) ? WIDTH_W : PRIME_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EIGHT_CONNECTED = 2'd2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1024;

    localparam logic [PIXEL_W-1:0] PIXEL_ZERO = 8'd0;
    localparam logic [PIXEL_W-1:0] PIXEL_FULL = 8'd255;

    typedef logic [1:0] class_t;

    localparam class_t CLASS_ZERO  = 2'd0;
    localparam class_t CLASS_FULL  = 2'd1;
    localparam class_t CLASS_OTHER = 2'd2;

    // one line store entry: classes of the two rows above the incoming one
    typedef struct packed {
        class_t upper;
        class_t middle;
    } line_entry_t;

    // one column of the 3x3 window
    typedef struct packed {
        class_t top;
        class_t mid;
        class_t bot;
    } win_col_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic up;
        logic down;
        logic left;
        logic right;
        logic eight;
    } emit_info_t;

    typedef struct packed {
        logic             push;
        logic [COL_W-1:0] addr;
        class_t           cls;
        emit_info_t       info;
    } step_t;

    typedef struct packed {
        logic       s1_emit;
        emit_info_t s2;
    } stage_status_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] border_value;
        logic               last_of_frame;
    } out_item_t;

    function automatic class_t classify(input logic [PIXEL_W-1:0] pix);
        class_t k;
        if (pix == PIXEL_ZERO)
            k = CLASS_ZERO;
        else if (pix == PIXEL_FULL)
            k = CLASS_FULL;
        else
            k = CLASS_OTHER;
        return k;
    endfunction

    // {seen zero, seen full} for one neighbour, nothing when it is absent
    function automatic logic [1:0] mark(input class_t k, input logic en);
        return {en && (k == CLASS_ZERO), en && (k == CLASS_FULL)};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bbe_if.sv =====
// stream interfaces for pixel requests and border results
`default_nettype none

interface bbe_pixel_if;
    import bbe_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_value;
    logic               flush;

    modport source (output valid, output pixel_value, output flush, input ready);
    modport sink   (input valid, input pixel_value, input flush, output ready);
endinterface

interface bbe_border_if;
    import bbe_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] border_value;
    logic               last_of_frame;

    modport source (output valid, output border_value, output last_of_frame, input ready);
    modport sink   (input valid, input border_value, input last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/bbe_ctrl.sv =====
// configuration registers, frame position counters and request acceptance
`default_nettype none

module bbe_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data,
    bbe_pixel_if.sink                           pixel_in,
    input  wire logic                           fifo_credit,
    output bbe_pkg::step_t                      step
);
    import bbe_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                eight_reg;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [PRIME_W-1:0]  prime_reg, prime_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [HEIGHT_W-1:0] out_row_reg, out_row_next;
    logic                dummy_reg, dummy_next;

    logic [CMP_W-1:0]    width_ext;
    logic [PRIME_W-1:0]  eff_w, w_last, w_plus1;
    logic [HEIGHT_W-1:0] eff_h, h_last;
    logic                col_at_end, row_last, in_done, primed;
    logic                out_col_end, out_row_end, out_last;
    logic                ready, fire, pix_push, flush_push, push, emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            eight_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:     width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:    height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_EIGHT_CONNECTED: eight_reg  <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        width_ext = CMP_W'(width_reg);
        if (width_reg == '0)
            eff_w = PRIME_W'(1);
        else if (width_ext > CMP_W'(MAX_WIDTH))
            eff_w = PRIME_W'(MAX_WIDTH);
        else
            eff_w = PRIME_W'(width_ext);
        w_last  = eff_w - PRIME_W'(1);
        w_plus1 = eff_w + PRIME_W'(1);
        eff_h   = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
        h_last  = eff_h - HEIGHT_W'(1);
    end

    always_comb
    begin
        col_at_end  = (PRIME_W'(col_reg) == w_last);
        row_last    = (row_reg == ROW_W'(h_last));
        in_done     = (row_reg >= ROW_W'(eff_h));
        primed      = (prime_reg == w_plus1);
        out_col_end = (PRIME_W'(out_col_reg) == w_last);
        out_row_end = (out_row_reg == h_last);
        out_last    = out_col_end && out_row_end;

        ready      = fifo_credit && !dummy_reg;
        fire       = pixel_in.valid && ready;
        pix_push   = fire && !pixel_in.flush && !in_done;
        flush_push = fire && pixel_in.flush && in_done;
        // a one-row frame needs one filler column so the window lines up
        push       = pix_push || flush_push || dummy_reg;
        emit       = (pix_push && primed) || flush_push;

        col_next     = col_reg;
        row_next     = row_reg;
        prime_next   = prime_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        dummy_next   = pix_push && col_at_end && row_last && (prime_reg < eff_w);

        if (push)
        begin
            if (col_at_end)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
            if (!primed)
                prime_next = prime_reg + PRIME_W'(1);
        end

        if (emit)
        begin
            if (out_col_end)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + HEIGHT_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
            // last output of the frame: start over at position zero
            if (out_last)
            begin
                col_next     = '0;
                row_next     = '0;
                prime_next   = '0;
                out_col_next = '0;
                out_row_next = '0;
                dummy_next   = 1'b0;
            end
        end

        pixel_in.ready  = ready;
        step.push       = push;
        step.addr       = col_reg;
        step.cls        = pix_push ? classify(pixel_in.pixel_value) : CLASS_ZERO;
        step.info.emit  = emit;
        step.info.last  = out_last;
        step.info.up    = (out_row_reg != '0);
        step.info.down  = !out_row_end;
        step.info.left  = (out_col_reg != '0);
        step.info.right = !out_col_end;
        step.info.eight = eight_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            prime_reg   <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            dummy_reg   <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            prime_reg   <= prime_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            dummy_reg   <= dummy_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bbe_line_store.sv =====
// line store memory with read-modify-write, forwarding and the 3x3 class window
`default_nettype none

module bbe_line_store (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  bbe_pkg::step_t            step,
    output bbe_pkg::win_col_t [2:0]   window,
    output bbe_pkg::stage_status_t    status
);
    import bbe_pkg::*;

    line_entry_t      mem [MAX_WIDTH];
    line_entry_t      rd_reg;
    line_entry_t      fwd_data_reg;
    logic             fwd_reg;
    step_t            s1_reg;
    emit_info_t       s2_reg;
    win_col_t [2:0]   win_reg;

    line_entry_t      cur;
    line_entry_t      wr_data;
    win_col_t         new_col;

    always_comb
    begin
        // back-to-back requests on the same column (width one) bypass the memory
        cur             = fwd_reg ? fwd_data_reg : rd_reg;
        wr_data.upper   = cur.middle;
        wr_data.middle  = s1_reg.cls;
        new_col.top     = cur.upper;
        new_col.mid     = cur.middle;
        new_col.bot     = s1_reg.cls;
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[step.addr];
        if (s1_reg.push)
            mem[s1_reg.addr] <= wr_data;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            fwd_reg <= 1'b0;
            win_reg <= '0;
        end
        else
        begin
            s1_reg  <= step;
            s2_reg  <= s1_reg.info;
            fwd_reg <= s1_reg.push && step.push && (s1_reg.addr == step.addr);
            if (s1_reg.push)
                win_reg <= {win_reg[1:0], new_col};
        end
    end

    assign window         = win_reg;
    assign status.s1_emit = s1_reg.info.emit;
    assign status.s2      = s2_reg;

endmodule

`default_nettype wire

// ===== rtl/bbe_out_fifo.sv =====
// border decision on the window and the result queue toward the output channel
`default_nettype none

module bbe_out_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  bbe_pkg::win_col_t [2:0]   window,
    input  bbe_pkg::stage_status_t    status,
    output logic                      credit,
    bbe_border_if.source              border_out
);
    import bbe_pkg::*;

    out_item_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic [FIFO_CNT_W:0]     pending;
    logic [1:0]              marks;
    logic                    is_border, en_diag;
    out_item_t               item;
    logic                    push, pop;

    always_comb
    begin
        en_diag = status.s2.eight;
        marks = mark(window[1].top, status.s2.up)
              | mark(window[1].bot, status.s2.down)
              | mark(window[2].mid, status.s2.left)
              | mark(window[0].mid, status.s2.right)
              | mark(window[2].top, en_diag && status.s2.up && status.s2.left)
              | mark(window[0].top, en_diag && status.s2.up && status.s2.right)
              | mark(window[2].bot, en_diag && status.s2.down && status.s2.left)
              | mark(window[0].bot, en_diag && status.s2.down && status.s2.right);
        is_border = (window[1].mid != CLASS_ZERO) && marks[1] && marks[0];
        item.border_value  = is_border ? PIXEL_FULL : PIXEL_ZERO;
        item.last_of_frame = status.s2.last;
    end

    always_comb
    begin
        push = status.s2.emit;
        pop  = (count_reg != '0) && border_out.ready;
        count_next = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        // room for every result still in the pipe plus one more request
        pending = (FIFO_CNT_W+1)'(count_reg) + (FIFO_CNT_W+1)'(status.s1_emit)
                + (FIFO_CNT_W+1)'(status.s2.emit);
        credit  = pending < (FIFO_CNT_W+1)'(FIFO_DEPTH);

        border_out.valid         = (count_reg != '0);
        border_out.border_value  = fifo_mem[rd_ptr_reg].border_value;
        border_out.last_of_frame = fifo_mem[rd_ptr_reg].last_of_frame;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/binary_border_extract_core.sv =====
// top level of the binary border extractor
//
//   channel     dir   handshake       payload
//   pixel_in    in    valid/ready     pixel_value[7:0], flush
//   border_out  out   valid/ready     border_value[7:0], last_of_frame
//   cfg         in    cfg_we          cfg_index[1:0], cfg_data[15:0]
//
// one request per clock while ready; it moves through s1_reg, s2_reg and the queue
// rate is set by the line store memory: one read and one write back per column
// a one-row frame pushes one filler column after its last pixel, with requests held off
// reset resets counters, window and config; the line store needs no clearing pass
// a four-entry result queue absorbs output stalls, requests stop when it could fill
`default_nettype none

module binary_border_extract_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    bbe_pixel_if.sink                           pixel_in,
    bbe_border_if.source                        border_out,
    input  wire logic                           cfg_we,
    input  wire logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bbe_pkg::*;

    step_t           step;
    win_col_t [2:0]  window;
    stage_status_t   status;
    logic            credit;

    bbe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_in    (pixel_in),
        .fifo_credit (credit),
        .step        (step)
    );

    bbe_line_store u_line_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .window (window),
        .status (status)
    );

    bbe_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .window     (window),
        .status     (status),
        .credit     (credit),
        .border_out (border_out)
    );

endmodule

`default_nettype wire

// ===== tb/tb_binary_border_extract_core.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the binary border extractor with a built-in border predictor

module tb_binary_border_extract_core;
    import bbe_pkg::*;

    localparam int unsigned RING_N        = 2 * MAX_WIDTH + 3;
    localparam int unsigned LIMIT_CYCLES  = 2_000_000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_GOAL   = 400;
    localparam int unsigned PRINT_CAP     = 40;

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               flush;
    } pixel_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bbe_pixel_if  pix_if ();
    bbe_border_if res_if ();

    binary_border_extract_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pix_if),
        .border_out (res_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // predictor state: class ring, raster counters and register copies
    class_t      ring_classes [RING_N];
    int unsigned model_col;
    int unsigned model_row;
    int unsigned model_out_pos;
    int unsigned model_width;
    int unsigned model_height;
    logic        model_eight;

    out_item_t  border_expected [$];
    pixel_req_t pixel_q [$];

    int unsigned cycle_count;
    int unsigned errors;
    int unsigned results_checked;
    int unsigned reqs_queued;
    int unsigned reqs_taken;
    int unsigned frames_sent;
    int unsigned setups_done;
    int unsigned hold_asks;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned send_gap;
    int unsigned recv_gap;
    bit          quiet;
    pixel_req_t  taken_req;
    out_item_t   want;

    function automatic void restart_frame_model();
        model_col     = 0;
        model_row     = 0;
        model_out_pos = 0;
    endfunction

    function automatic void note_neighbour(input int unsigned pos, inout bit seen_zero,
                                           inout bit seen_full);
        class_t k;
        k = ring_classes[pos % RING_N];
        if (k == CLASS_ZERO)
            seen_zero = 1'b1;
        else if (k == CLASS_FULL)
            seen_full = 1'b1;
    endfunction

    function automatic void emit_border(input int unsigned w, input int unsigned h,
                                        input int unsigned total);
        int unsigned p;
        int unsigned r;
        int unsigned c;
        bit          up;
        bit          down;
        bit          left;
        bit          right;
        bit          z;
        bit          f;
        out_item_t   e;
        p     = model_out_pos;
        r     = p / w;
        c     = p % w;
        up    = r > 0;
        down  = r + 1 < h;
        left  = c > 0;
        right = c + 1 < w;
        z     = 1'b0;
        f     = 1'b0;
        if (up)
            note_neighbour(p - w, z, f);
        if (down)
            note_neighbour(p + w, z, f);
        if (left)
            note_neighbour(p - 1, z, f);
        if (right)
            note_neighbour(p + 1, z, f);
        if (model_eight)
        begin
            if (up && left)
                note_neighbour(p - w - 1, z, f);
            if (up && right)
                note_neighbour(p - w + 1, z, f);
            if (down && left)
                note_neighbour(p + w - 1, z, f);
            if (down && right)
                note_neighbour(p + w + 1, z, f);
        end
        if (ring_classes[p % RING_N] != CLASS_ZERO && z && f)
            e.border_value = PIXEL_FULL;
        else
            e.border_value = PIXEL_ZERO;
        e.last_of_frame = (p + 1 == total);
        border_expected.push_back(e);
        model_out_pos++;
        if (model_out_pos >= total)
            restart_frame_model();
    endfunction

    // one accepted request through the predictor
    function automatic void advance_border_model(input pixel_req_t rq);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned n_in;
        w = (model_width < 1) ? 1 : ((model_width > MAX_WIDTH) ? MAX_WIDTH : model_width);
        h = (model_height < 1) ? 1 : model_height;
        total = w * h;
        if (model_out_pos >= total)
            restart_frame_model();
        if (!rq.flush)
        begin
            if (model_row < h)
            begin
                n_in = model_row * w + model_col;
                if (rq.pixel == PIXEL_ZERO)
                    ring_classes[n_in % RING_N] = CLASS_ZERO;
                else if (rq.pixel == PIXEL_FULL)
                    ring_classes[n_in % RING_N] = CLASS_FULL;
                else
                    ring_classes[n_in % RING_N] = CLASS_OTHER;
                model_col++;
                if (model_col >= w)
                begin
                    model_col = 0;
                    model_row++;
                end
                n_in++;
                if (model_out_pos < total && model_out_pos + w + 1 < n_in)
                    emit_border(w, h, total);
            end
        end
        else if (model_row >= h && model_out_pos < total)
        begin
            emit_border(w, h, total);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] got,
                                   input logic [PIXEL_W-1:0] exp_val);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
                     what, cycle_count, got, exp_val);
    endtask

    function automatic void push_req(input logic [PIXEL_W-1:0] pix, input logic fl);
        pixel_req_t rq;
        rq.pixel = pix;
        rq.flush = fl;
        pixel_q.push_back(rq);
        reqs_queued++;
    endfunction

    // one frame of pixels plus drain flushes; returns the requests that do work
    function automatic int unsigned queue_frame(input int unsigned w, input int unsigned h,
                                                input int style, input bit noisy);
        int unsigned        n;
        int unsigned        stray_at;
        int unsigned        k;
        logic [PIXEL_W-1:0] pix;
        n = w * h;
        stray_at = (noisy && $urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : n;
        for (k = 0; k < n; k++)
        begin
            // flush before the frame is complete is dropped
            if (k == stray_at)
                push_req(PIXEL_W'($urandom_range(0, 255)), 1'b1);
            case (style)
                0:       pix = $urandom_range(0, 1) ? PIXEL_FULL : PIXEL_ZERO;
                1:       pix = ($urandom_range(0, 4) == 0) ? PIXEL_W'($urandom_range(1, 254)) :
                               ($urandom_range(0, 1) ? PIXEL_FULL : PIXEL_ZERO);
                default: pix = PIXEL_W'($urandom_range(0, 255));
            endcase
            push_req(pix, 1'b0);
        end
        // pixels past the frame end are dropped until the drain is done
        if (noisy && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) push_req(PIXEL_W'($urandom_range(0, 255)), 1'b0);
        for (k = 0; k <= w; k++)
            push_req(PIXEL_W'($urandom_range(0, 255)), 1'b1);
        if (noisy && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) push_req(PIXEL_W'($urandom_range(0, 255)), 1'b1);
        frames_sent++;
        return n + ((n < w + 1) ? n : w + 1);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:     model_width  = 32'(data[WIDTH_W-1:0]);
            REG_IMAGE_HEIGHT:    model_height = 32'(data[HEIGHT_W-1:0]);
            REG_EIGHT_CONNECTED: model_eight  = data[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (reqs_taken != reqs_queued || border_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // registers change only with the block idle
    task automatic set_geometry(input int unsigned width_raw, input int unsigned height_raw,
                                input bit eight);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(width_raw));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(height_raw));
        write_reg(REG_EIGHT_CONNECTED, CFG_DATA_W'(eight));
        setups_done++;
        @(negedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_if.valid       <= 1'b0;
            pix_if.pixel_value <= '0;
            pix_if.flush       <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (pix_if.valid && pix_if.ready)
            begin
                taken_req.pixel = pix_if.pixel_value;
                taken_req.flush = pix_if.flush;
                advance_border_model(taken_req);
                reqs_taken++;
            end
            if (!pix_if.valid || pix_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pix_if.valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 11) == 0)
                begin
                    send_gap = $urandom_range(1, 18) - 1;
                    pix_if.valid <= 1'b0;
                end
                else if (pixel_q.size() != 0)
                begin
                    taken_req = pixel_q.pop_front();
                    pix_if.valid       <= 1'b1;
                    pix_if.pixel_value <= taken_req.pixel;
                    pix_if.flush       <= taken_req.flush;
                end
                else
                begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and ready pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            hold_left = 0;
            recv_gap = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (border_expected.size() == 0)
                begin
                    report_mismatch("unexpected result", res_if.border_value, PIXEL_ZERO);
                end
                else
                begin
                    want = border_expected.pop_front();
                    results_checked++;
                    if (res_if.border_value !== want.border_value)
                        report_mismatch("border_value", res_if.border_value,
                                        want.border_value);
                    if (res_if.last_of_frame !== want.last_of_frame)
                        report_mismatch("last_of_frame", PIXEL_W'(res_if.last_of_frame),
                                        PIXEL_W'(want.last_of_frame));
                end
            end
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                res_if.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 18) - 1;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_binary_border_extract_core NOT OK");
            $finish;
        end
    end

    initial
    begin
        int unsigned random_reqs;
        int unsigned phase_no;
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int          style;
        bit          hold_phase;

        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        foreach (ring_classes[i])
            ring_classes[i] = CLASS_ZERO;
        restart_frame_model();
        model_width  = 32'(WIDTH_RESET);
        model_height = 32'(HEIGHT_RESET);
        model_eight  = 1'b0;
        random_reqs  = 0;
        phase_no     = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 3x3 frame, 8-adjacency, with dropped requests around it
        set_geometry(3, 3, 1'b1);
        push_req(PIXEL_FULL, 1'b0);
        push_req(PIXEL_ZERO, 1'b0);
        push_req(PIXEL_FULL, 1'b0);
        push_req(PIXEL_ZERO, 1'b0);
        push_req(8'hA5, 1'b1);
        push_req(PIXEL_FULL, 1'b0);
        push_req(8'd128, 1'b0);
        push_req(PIXEL_FULL, 1'b0);
        push_req(8'd1, 1'b0);
        push_req(8'd254, 1'b0);
        push_req(PIXEL_FULL, 1'b0);
        repeat (4) push_req(8'h5A, 1'b1);
        push_req(8'hFF, 1'b1);
        frames_sent++;

        // single pixel frame, 4-adjacency
        set_geometry(1, 1, 1'b0);
        push_req(8'd77, 1'b0);
        push_req(8'h00, 1'b1);
        push_req(8'h3C, 1'b1);
        frames_sent++;

        while (random_reqs < RANDOM_GOAL)
        begin
            hold_phase = (phase_no == 0 || phase_no == 3);
            if (hold_phase)
            begin
                w = 24;
                h = 6;
            end
            else
            begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            end
            set_geometry(w, h, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3))
            begin
                r = $urandom_range(0, 9);
                style = (r < 6) ? 0 : ((r < 9) ? 1 : 2);
                random_reqs += queue_frame(w, h, style, 1'b1);
            end
            // long output stall while requests keep coming
            if (hold_phase)
                hold_asks++;
            phase_no++;
        end

        quiet = 1'b1;
        // width above range acts as the maximum, height zero as one row
        set_geometry(2047, 0, 1'b0);
        void'(queue_frame(MAX_WIDTH, 1, 1, 1'b0));
        // width zero acts as one column
        set_geometry(0, 40, 1'b1);
        void'(queue_frame(1, 40, 1, 1'b0));

        wait_drained();

        $display("covered %0d frames over %0d register setups, %0d requests accepted",
                 frames_sent, setups_done, reqs_taken);
        $display("%0d border results checked, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("tb_binary_border_extract_core OK");
        else
            $display("tb_binary_border_extract_core NOT OK");
        $finish;
    end

endmodule

// ===== binary_border_extract_core.f =====
rtl/bbe_pkg.sv
rtl/bbe_if.sv
rtl/bbe_ctrl.sv
rtl/bbe_line_store.sv
rtl/bbe_out_fifo.sv
rtl/binary_border_extract_core.sv
tb/tb_binary_border_extract_core.sv
